### design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// types and constants shared by the periodic timer table
// ----------------------------------------------------------------------------
package ptt_pkg;

   typedef enum logic [3:0] {
      ACT_TICK     = 4'd0,
      ACT_ADD      = 4'd1,
      ACT_PAUSE    = 4'd2,
      ACT_RESUME   = 4'd3,
      ACT_RESET    = 4'd4,
      ACT_KILL     = 4'd5,
      ACT_KILL_ALL = 4'd6,
      ACT_SET_IVL  = 4'd7,
      ACT_QUERY    = 4'd8,
      ACT_RUN      = 4'd9
   } action_type;

   typedef enum logic [1:0] {
      MODE_ACTIVE = 2'd0,
      MODE_PAUSED = 2'd1,
      MODE_DEAD   = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [3:0]        action;
      logic [7:0]        target_id;
      logic [15:0]       period_ms;
      logic [15:0]       start_offset;
      logic signed [7:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic [7:0]        result_id;
      logic              found;
      logic              fired;
      logic [15:0]       interval_out;
      logic signed [7:0] remaining_out;
      logic [31:0]       last_run_out;
      logic              last;
   } rsp_type;

   // one timer entry; ident width is fixed at the widest id
   typedef struct packed {
      logic [15:0] ident;
      logic [15:0] period;
      logic [7:0]  remaining;
      mode_type    mode;
      logic [31:0] last_run;
      logic [31:0] elapsed;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic        pause;
      logic        resume;
      logic        rst_tmr;
      logic        kill;
      logic        kill_all;
      logic        set_ivl;
      logic        fire_chk;
      logic [15:0] target;
      logic [15:0] period;
      logic [31:0] now;
   } cmd_type;

endpackage

### design/ptt_cell.sv
// ----------------------------------------------------------------------------
// ptt_cell
// one timer slot of the chain: applies commands and shifts toward the head
// ----------------------------------------------------------------------------
module ptt_cell (
   input  logic               clock,
   input  logic               reset,
   input  ptt_pkg::cmd_type   cmd,
   input  logic               apply,
   input  logic               shift,
   input  logic               load,
   input  ptt_pkg::entry_type load_entry,
   input  logic               nbr_valid,
   input  ptt_pkg::entry_type nbr_entry,
   output logic               valid,
   output ptt_pkg::entry_type entry,
   output logic               hit,
   output logic               fire
);
   import ptt_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      due;
   logic      rem_zero;

   assign hit      = valid_ff && (cmd.target != '0) && (entry_ff.ident == cmd.target);
   assign due      = ((cmd.now - entry_ff.last_run) >= {16'd0, entry_ff.period});
   assign rem_zero = (entry_ff.remaining == 8'd0);
   assign fire     = valid_ff && cmd.fire_chk && due && !rem_zero &&
                     (entry_ff.mode == MODE_ACTIVE);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (load) begin
         valid_in = 1'b1;
         entry_in = load_entry;
      end else if (shift) begin
         valid_in = nbr_valid;
         entry_in = nbr_entry;
      end else if (apply && valid_ff) begin
         if (cmd.kill_all) begin
            entry_in.mode = MODE_DEAD;
         end else if (cmd.fire_chk) begin
            if (fire) begin
               entry_in.last_run = cmd.now;
               if (!entry_ff.remaining[7]) begin
                  entry_in.remaining = entry_ff.remaining - 8'd1;
                  if (entry_ff.remaining == 8'd1) begin
                     entry_in.mode = MODE_DEAD;
                  end
               end
            end else if (rem_zero) begin
               entry_in.mode = MODE_DEAD;
            end
         end else if (hit) begin
            if (cmd.pause && entry_ff.mode == MODE_ACTIVE) begin
               entry_in.mode    = MODE_PAUSED;
               entry_in.elapsed = cmd.now - entry_ff.last_run;
            end else if (cmd.resume && entry_ff.mode == MODE_PAUSED) begin
               entry_in.last_run = cmd.now - {16'd0, entry_ff.period} + entry_ff.elapsed;
               entry_in.mode     = MODE_ACTIVE;
            end else if (cmd.rst_tmr) begin
               entry_in.last_run = cmd.now;
               entry_in.elapsed  = {16'd0, entry_ff.period};
            end else if (cmd.kill) begin
               entry_in.mode = MODE_DEAD;
            end else if (cmd.set_ivl) begin
               entry_in.period = cmd.period;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

### design/periodic_task_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// periodic timer table held in a chain of slot cells, kept in insertion order
// ----------------------------------------------------------------------------
// channel  dir  ports                    payload
// request  in   req_valid / req_stall    req_data  (ptt_pkg::req_type)
// response out  rsp_valid / rsp_stall    rsp_data  (ptt_pkg::rsp_type)
//
// commands pass through an execute and an output state; add searches for a free
// id, one candidate per cycle against all cells in parallel.
// run walks every cell (one step each, when the response slot is free), then
// compacts the chain, one shift or step a cycle.
// reset clears the valid bit of every cell and the tick counter, and sets the id to 1.
// a stalled response holds the walk and the final response step; the request is stalled while busy.
// ----------------------------------------------------------------------------
module periodic_task_timer_table #(
   parameter int SLOTS   = 8,
   parameter int ID_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptt_pkg::rsp_type rsp_data
);
   import ptt_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [15:0] ID_MAX = 16'((32'd1 << ID_BITS) - 32'd1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_ALLOC = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_PACK  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [31:0] now_ff, now_in;
   logic [15:0] nfid_ff, nfid_in;
   logic [15:0] cand_ff, cand_in;
   logic [15:0] tries_ff, tries_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // the pending response of the current request; during a run it holds the
   // latest firing so the final one can carry last
   rsp_type     hold_ff, hold_in;
   logic        hold_v_ff, hold_v_in;

   cmd_type   cmd;
   logic [SLOTS-1:0] apply, shift, load, hits, fires, valids, cand_hits;
   entry_type ents [SLOTS];
   entry_type new_ent;
   logic [CW-1:0] count;
   logic [15:0] cand_next;

   assign cand_next = (cand_ff >= ID_MAX) ? 16'd1 : cand_ff + 16'd1;

   always_comb begin
      count = '0;
      for (int i = 0; i < SLOTS; i++) begin
         count = count + CW'(valids[i]);
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.target   = {8'd0, req_ff.target_id};
      cmd.period   = req_ff.period_ms;
      cmd.now      = now_ff;
      cmd.pause    = (req_ff.action == ACT_PAUSE);
      cmd.resume   = (req_ff.action == ACT_RESUME);
      cmd.rst_tmr  = (req_ff.action == ACT_RESET);
      cmd.kill     = (req_ff.action == ACT_KILL);
      cmd.kill_all = (req_ff.action == ACT_KILL_ALL);
      cmd.set_ivl  = (req_ff.action == ACT_SET_IVL);
      cmd.fire_chk = (state_ff == ST_WALK);
      new_ent           = '0;
      new_ent.ident     = cand_ff;
      new_ent.period    = req_ff.period_ms;
      new_ent.remaining = req_ff.repeat_count;
      new_ent.mode      = MODE_ACTIVE;
      new_ent.last_run  = now_ff - {16'd0, req_ff.period_ms} + {16'd0, req_ff.start_offset};
      new_ent.elapsed   = '0;
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      logic      nv;
      entry_type ne;
      if (g == SLOTS - 1) begin : g_tail
         assign nv = 1'b0;
         assign ne = '0;
      end else begin : g_mid
         assign nv = valids[g+1];
         assign ne = ents[g+1];
      end
      assign cand_hits[g] = valids[g] && (ents[g].ident == cand_ff);
      ptt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .apply      (apply[g]),
         .shift      (shift[g]),
         .load       (load[g]),
         .load_entry (new_ent),
         .nbr_valid  (nv),
         .nbr_entry  (ne),
         .valid      (valids[g]),
         .entry      (ents[g]),
         .hit        (hits[g]),
         .fire       (fires[g])
      );
   end

   // compaction: at position pos, if that cell is dead, shift pos and above
   logic pack_dead;
   assign pack_dead = (pos_ff < CW'(SLOTS)) && valids[IW'(pos_ff)] &&
                      (ents[IW'(pos_ff)].mode == MODE_DEAD);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      now_in       = now_ff;
      nfid_in      = nfid_ff;
      cand_in      = cand_ff;
      tries_in     = tries_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      hold_v_in    = hold_v_ff;
      apply        = '0;
      shift        = '0;
      load         = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            hold_in      = '0;
            hold_in.last = 1'b1;
            hold_v_in    = 1'b0;
            state_in     = ST_OUT;
            case (req_ff.action)
               ACT_TICK: now_in = now_ff + 32'd1;
               ACT_ADD: begin
                  cand_in  = (nfid_ff == '0 || nfid_ff > ID_MAX) ? 16'd1 : nfid_ff;
                  tries_in = '0;
                  if (req_ff.period_ms != '0 && count < CW'(SLOTS)) begin
                     state_in = ST_ALLOC;
                  end
               end
               ACT_PAUSE, ACT_RESUME, ACT_RESET, ACT_KILL, ACT_SET_IVL, ACT_QUERY: begin
                  hold_in.found = |hits;
                  apply         = '1;
                  if (req_ff.action == ACT_QUERY) begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if (hits[i]) begin
                           hold_in.interval_out  = ents[i].period;
                           hold_in.remaining_out = ents[i].remaining;
                           hold_in.last_run_out  = ents[i].last_run;
                        end
                     end
                  end
               end
               ACT_KILL_ALL: apply = '1;
               ACT_RUN: begin
                  idx_in   = '0;
                  state_in = ST_WALK;
               end
               default: ;
            endcase
         end
         ST_ALLOC: begin
            if (!(|cand_hits)) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (CW'(i) == count) load[i] = 1'b1;
               end
               nfid_in           = cand_next;
               hold_in.result_id = cand_ff[7:0];
               state_in          = ST_OUT;
            end else if (tries_ff == ID_MAX - 16'd1) begin
               state_in = ST_OUT;
            end else begin
               cand_in  = cand_next;
               tries_in = tries_ff + 16'd1;
            end
         end
         ST_WALK: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               apply[idx_ff] = 1'b1;
               if (fires[idx_ff]) begin
                  if (hold_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = hold_ff;
                  end
                  hold_in           = '0;
                  hold_in.result_id = ents[idx_ff].ident[7:0];
                  hold_in.fired     = 1'b1;
                  hold_v_in         = 1'b1;
               end
               if (idx_ff == IW'(SLOTS - 1)) begin
                  pos_in   = '0;
                  state_in = ST_PACK;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         ST_PACK: begin
            if (pos_ff >= CW'(SLOTS)) begin
               state_in = ST_OUT;
            end else if (pack_dead) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (CW'(i) >= pos_ff) shift[i] = 1'b1;
               end
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = hold_ff;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               hold_v_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         nfid_ff      <= 16'd1;
         rsp_valid_ff <= 1'b0;
         hold_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         nfid_ff      <= nfid_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_v_ff    <= hold_v_in;
      end
      req_ff   <= req_in;
      cand_ff  <= cand_in;
      tries_ff <= tries_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
      hold_ff  <= hold_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_req_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(SLOTS))
      else $error("entry count overflow");
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && req_ff.action == ACT_TICK) |=> now_ff == $past(now_ff) + 32'd1)
      else $error("tick count step");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

### sim/tb_periodic_task_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_timer_table
// self-checking bench for the periodic timer table: a queue-fed driver sends
// directed then random requests, a predictor tracks the table and every
// response is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_table;
   import ptt_pkg::*;

   localparam int SLOTS = 8;
   localparam int ID_MAX = 255;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   periodic_task_timer_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor state
   logic [31:0]       now_cnt;
   logic [7:0]        free_id;
   int                n_timers;
   logic [7:0]        t_id      [SLOTS];
   logic [15:0]       t_period  [SLOTS];
   logic signed [7:0] t_left    [SLOTS];
   mode_type          t_mode    [SLOTS];
   logic [31:0]       t_last    [SLOTS];
   logic [31:0]       t_elapsed [SLOTS];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   int      n_sent = 0;
   int      n_rsps = 0;
   int      n_fired = 0;
   bit      calm = 0;
   bit      hold = 0;
   bit      req_taken = 0;

   function automatic int find_timer(logic [7:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < n_timers; i++)
         if (t_id[i] == id) return i;
      return -1;
   endfunction

   function automatic rsp_type zero_rsp();
      rsp_type r;
      r = '0;
      return r;
   endfunction

   task automatic predict_request(req_type q);
      rsp_type r;
      int      t;
      int      nres;
      int      w;
      logic [7:0] cand;
      logic [7:0] nid;
      r = zero_rsp();
      t = find_timer(q.target_id);
      nres = 0;
      case (q.action)
         ACT_TICK: now_cnt++;
         ACT_ADD: begin
            nid = 0;
            if (q.period_ms != 0 && n_timers < SLOTS) begin
               cand = (free_id == 0) ? 8'd1 : free_id;
               for (int k = 0; k < ID_MAX; k++) begin
                  if (find_timer(cand) < 0) begin
                     nid = cand;
                     free_id = (cand == ID_MAX) ? 8'd1 : cand + 8'd1;
                     break;
                  end
                  cand = (cand == ID_MAX) ? 8'd1 : cand + 8'd1;
               end
            end
            if (nid != 0) begin
               t_id[n_timers] = nid;
               t_period[n_timers] = q.period_ms;
               t_left[n_timers] = q.repeat_count;
               t_mode[n_timers] = MODE_ACTIVE;
               t_last[n_timers] = now_cnt - q.period_ms + q.start_offset;
               t_elapsed[n_timers] = 0;
               n_timers++;
            end
            r.result_id = nid;
         end
         ACT_PAUSE, ACT_RESUME, ACT_RESET, ACT_KILL, ACT_SET_IVL, ACT_QUERY: begin
            if (t >= 0) begin
               r.found = 1;
               if (q.action == ACT_PAUSE && t_mode[t] == MODE_ACTIVE) begin
                  t_mode[t] = MODE_PAUSED;
                  t_elapsed[t] = now_cnt - t_last[t];
               end else if (q.action == ACT_RESUME && t_mode[t] == MODE_PAUSED) begin
                  t_last[t] = now_cnt - t_period[t] + t_elapsed[t];
                  t_mode[t] = MODE_ACTIVE;
               end else if (q.action == ACT_RESET) begin
                  t_last[t] = now_cnt;
                  t_elapsed[t] = t_period[t];
               end else if (q.action == ACT_KILL) begin
                  t_mode[t] = MODE_DEAD;
               end else if (q.action == ACT_SET_IVL) begin
                  t_period[t] = q.period_ms;
               end else if (q.action == ACT_QUERY) begin
                  r.interval_out = t_period[t];
                  r.remaining_out = t_left[t];
                  r.last_run_out = t_last[t];
               end
            end
         end
         ACT_KILL_ALL: for (int i = 0; i < n_timers; i++) t_mode[i] = MODE_DEAD;
         ACT_RUN: begin
            for (int i = 0; i < n_timers; i++) begin
               if (now_cnt - t_last[i] >= {16'd0, t_period[i]} && t_left[i] != 0 &&
                   t_mode[i] == MODE_ACTIVE) begin
                  r = zero_rsp();
                  r.result_id = t_id[i];
                  r.fired = 1;
                  expected_rsps.push_back(r);
                  nres++;
                  n_fired++;
                  t_last[i] = now_cnt;
                  if (t_left[i] > 0) t_left[i]--;
               end
               if (t_left[i] == 0) t_mode[i] = MODE_DEAD;
            end
            w = 0;
            for (int i = 0; i < n_timers; i++) begin
               if (t_mode[i] != MODE_DEAD) begin
                  t_id[w] = t_id[i]; t_period[w] = t_period[i];
                  t_left[w] = t_left[i]; t_mode[w] = t_mode[i];
                  t_last[w] = t_last[i]; t_elapsed[w] = t_elapsed[i];
                  w++;
               end
            end
            n_timers = w;
            r = zero_rsp();
         end
         default: ;
      endcase
      if (nres == 0) begin
         r.last = 1;
         expected_rsps.push_back(r);
      end else begin
         r = expected_rsps.pop_back();
         r.last = 1;
         expected_rsps.push_back(r);
      end
   endtask

   function automatic req_type make_req(action_type a, logic [7:0] id, logic [15:0] p,
                                        logic [15:0] o, logic [7:0] rc);
      req_type q;
      q.action = a; q.target_id = id; q.period_ms = p;
      q.start_offset = o; q.repeat_count = rc;
      return q;
   endfunction

   // random request, mostly targeting ids likely to exist
   function automatic req_type rand_req();
      req_type    q;
      int         sel;
      q = req_type'($bits(req_type)'({$urandom, $urandom}));
      sel = $urandom_range(0, 99);
      if (sel < 30) q.action = ACT_TICK;
      else if (sel < 45) q.action = ACT_ADD;
      else if (sel < 60) q.action = ACT_RUN;
      else if (sel < 62) q.action = ACT_KILL_ALL;
      else if (sel < 64) q.action = 4'($urandom_range(10, 15));
      else q.action = 4'($urandom_range(2, 8));
      if (q.action == ACT_KILL_ALL && $urandom_range(0, 1)) q.action = ACT_QUERY;
      if ($urandom_range(0, 9) < 8) begin
         q.period_ms = 16'($urandom_range(0, 6));
         q.start_offset = 16'($urandom_range(0, 6));
         q.target_id = 8'($urandom_range(0, 24));
         if ($urandom_range(0, 3) != 0) q.repeat_count = 8'($urandom_range(0, 4)) - 8'd1;
      end
      return q;
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // request handshake seen at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_data <= '0;
         rsp_stall <= 0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() != 0 && !hold &&
                (calm || $urandom_range(0, 99) >= 24)) begin
               req_data <= pending_reqs[0];
               req_valid <= 1;
               predict_request(pending_reqs.pop_front());
               n_sent++;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsps++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.result_id !== e.result_id) begin
               $error("result_id exp %0d got %0d", e.result_id, rsp_data.result_id); errors++;
            end
            if (rsp_data.found !== e.found) begin
               $error("found exp %0d got %0d", e.found, rsp_data.found); errors++;
            end
            if (rsp_data.fired !== e.fired) begin
               $error("fired exp %0d got %0d", e.fired, rsp_data.fired); errors++;
            end
            if (rsp_data.interval_out !== e.interval_out) begin
               $error("interval_out exp %0d got %0d", e.interval_out, rsp_data.interval_out);
               errors++;
            end
            if (rsp_data.remaining_out !== e.remaining_out) begin
               $error("remaining_out exp %0d got %0d", e.remaining_out,
                      rsp_data.remaining_out);
               errors++;
            end
            if (rsp_data.last_run_out !== e.last_run_out) begin
               $error("last_run_out exp %0d got %0d", e.last_run_out, rsp_data.last_run_out);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last); errors++;
            end
         end
      end
   end

   initial begin
      now_cnt = 0; free_id = 1; n_timers = 0;
      req_valid = 0; req_data = '0; rsp_stall = 0;
      reset = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: refused adds, extremes, each action, full table
      pending_reqs.push_back(make_req(ACT_QUERY, 8'd0, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_ADD, 8'hFF, 16'd0, 16'hFFFF, 8'h7F));
      pending_reqs.push_back(make_req(ACT_ADD, 8'd0, 16'hFFFF, 16'hFFFF, 8'h80));
      pending_reqs.push_back(make_req(ACT_ADD, 8'd0, 16'd1, 16'd0, 8'd2));
      pending_reqs.push_back(make_req(ACT_ADD, 8'd0, 16'd2, 16'd1, 8'd0));
      pending_reqs.push_back(make_req(ACT_ADD, 8'd0, 16'd3, 16'd3, 8'hFF));
      for (int i = 0; i < 5; i++)
         pending_reqs.push_back(make_req(ACT_ADD, 8'd0, 16'd1, 16'd1, 8'd1));
      pending_reqs.push_back(make_req(ACT_TICK, 8'd0, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_PAUSE, 8'd3, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_RESUME, 8'd3, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_RESET, 8'd2, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_KILL, 8'd4, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_QUERY, 8'd4, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_SET_IVL, 8'd1, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_RUN, 8'd0, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_QUERY, 8'hFF, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(action_type'(4'hF), 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      pending_reqs.push_back(make_req(ACT_KILL_ALL, 8'd0, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_RUN, 8'd0, 16'd0, 16'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_RUN, 8'd0, 16'd0, 16'd0, 8'd0));
      wait (pending_reqs.size() == 0);
      // hold off until every expected response has been checked
      hold = 1;
      wait (expected_rsps.size() == 0);
      repeat (4) @(negedge clock);
      hold = 0;
      for (int i = 0; i < 207; i++) pending_reqs.push_back(rand_req());
      wait (pending_reqs.size() < 130);
      calm = 1;
      wait (pending_reqs.size() < 80);
      calm = 0;
      wait (pending_reqs.size() == 0);
      wait (expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      $display("sent %0d requests, checked %0d responses, %0d timer firings",
               n_sent, n_rsps, n_fired);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
